[src/vmt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmt_pkg: shared types and constants for the vertex matrix transform
// Widths, fixed-point format and matrix reset values (identity).
// ----------------------------------------------------------------------------
package vmt_pkg;

  // fixed-point format of coefficients and components
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;

  // matrix register file
  localparam int NUM_REGS   = 8;
  localparam int REG_SEL_W  = $clog2(NUM_REGS);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 2 * DATA_W;

  // arithmetic widths through the datapath
  localparam int PROD_W     = 2 * DATA_W;
  localparam int PAIR_W     = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int SHR_W      = SUM_W - FRAC_BITS;

  typedef logic signed [DATA_W-1:0] comp_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

  localparam comp_t COMP_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // identity matrix, two coefficients per register, even column low
  localparam cfg_data_t REG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

endpackage

[src/vmt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmt_if: channel interfaces of the vertex matrix transform
// Vertex input, transformed result and matrix configuration write channels.
// ----------------------------------------------------------------------------

// vertex input channel
interface vmt_in_if;
  import vmt_pkg::*;
  logic  valid;
  logic  ready;
  comp_t vec_x;
  comp_t vec_y;
  comp_t vec_z;
  comp_t vec_w;
  modport source (output valid, vec_x, vec_y, vec_z, vec_w, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

// transformed vertex channel
interface vmt_out_if;
  import vmt_pkg::*;
  logic  valid;
  logic  ready;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;
  comp_t out_w;
  logic  saturated;
  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

// matrix register write channel
interface vmt_cfg_if;
  import vmt_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  idx;
  cfg_data_t wdata;
  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

[src/vertex_matrix_transform_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_matrix_transform_unit: 4x4 matrix times homogeneous vertex, Q16.16
// Five-stage pipeline: input register, 16 multipliers, pair sums, row sums,
// floor shift with saturation into the output register.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------
//  vertex   | in  | valid / ready | vec_x, vec_y, vec_z, vec_w
//  result   | out | valid / ready | out_x, out_y, out_z, out_w, saturated
//  cfg      | in  | valid / ready | idx (0..7 matrix register), wdata (64 bit)
//
//  one vertex per cycle sustained while the result is not stalled
//  the rate is set by the fully pipelined multiplier bank (one product per cell)
//  rst is synchronous; it empties the pipeline and loads the identity matrix
//  a stalled result holds each full stage with no empty stage after it; empty stages still fill
//  cfg is always ready; a write to an index of 8 or above is dropped
// ----------------------------------------------------------------------------
module vertex_matrix_transform_unit (
  input  logic        clk,
  input  logic        rst,
  vmt_in_if.sink      vertex,
  vmt_out_if.source   result,
  vmt_cfg_if.sink     cfg
);
  import vmt_pkg::*;

  localparam int NSTG = 5;

  // matrix registers
  cfg_data_t mat [NUM_REGS];
  comp_t     coef [4][4];

  // pipeline control
  logic [NSTG-1:0] stg_valid;
  logic [NSTG-1:0] stg_ready;

  // pipeline data
  comp_t                    s0_vec  [4];
  logic signed [PROD_W-1:0] s1_prod [4][4];
  logic signed [PAIR_W-1:0] s2_pair [4][2];
  logic signed [SUM_W-1:0]  s3_sum  [4];
  comp_t                    s4_out  [4];
  logic                     s4_sat;

  // saturation logic
  logic signed [SHR_W-1:0]  shr     [4];
  comp_t                    clip    [4];
  logic [3:0]               row_sat;

  // matrix register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        mat[i] <= REG_RESET[i];
      end
    end else if (cfg.valid && cfg.ready && (cfg.idx < CFG_IDX_W'(NUM_REGS))) begin
      mat[cfg.idx[REG_SEL_W-1:0]] <= cfg.wdata;
    end
  end

  // coefficient unpacking, even column in the low half
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign coef[r][c] = comp_t'(mat[2*r + c/2][DATA_W*(c%2) +: DATA_W]);
    end
  end

  // ready chain: a stage advances when empty or when the next one advances
  always_comb begin
    stg_ready[NSTG-1] = !stg_valid[NSTG-1] || result.ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      stg_ready[k] = !stg_valid[k] || stg_ready[k+1];
    end
  end

  assign vertex.ready = stg_ready[0];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      if (stg_ready[0]) begin
        stg_valid[0] <= vertex.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (stg_ready[k]) begin
          stg_valid[k] <= stg_valid[k-1];
        end
      end
    end
  end

  // stage 0: capture the vertex
  always_ff @(posedge clk) begin
    if (stg_ready[0]) begin
      s0_vec[0] <= vertex.vec_x;
      s0_vec[1] <= vertex.vec_y;
      s0_vec[2] <= vertex.vec_z;
      s0_vec[3] <= vertex.vec_w;
    end
  end

  // stage 1: sixteen full-precision products
  always_ff @(posedge clk) begin
    if (stg_ready[1]) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          s1_prod[r][c] <= PROD_W'(s0_vec[c]) * PROD_W'(coef[r][c]);
        end
      end
    end
  end

  // stage 2: pairwise sums per row
  always_ff @(posedge clk) begin
    if (stg_ready[2]) begin
      for (int r = 0; r < 4; r++) begin
        s2_pair[r][0] <= PAIR_W'(s1_prod[r][0]) + PAIR_W'(s1_prod[r][1]);
        s2_pair[r][1] <= PAIR_W'(s1_prod[r][2]) + PAIR_W'(s1_prod[r][3]);
      end
    end
  end

  // stage 3: exact row sums
  always_ff @(posedge clk) begin
    if (stg_ready[3]) begin
      for (int r = 0; r < 4; r++) begin
        s3_sum[r] <= SUM_W'(s2_pair[r][0]) + SUM_W'(s2_pair[r][1]);
      end
    end
  end

  // floor shift and clip to 32 bits
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      shr[r]     = SHR_W'(s3_sum[r] >>> FRAC_BITS);
      row_sat[r] = (shr[r][SHR_W-1:DATA_W-1] != {(SHR_W-DATA_W+1){1'b0}}) &&
                   (shr[r][SHR_W-1:DATA_W-1] != {(SHR_W-DATA_W+1){1'b1}});
      if (!row_sat[r]) begin
        clip[r] = comp_t'(shr[r][DATA_W-1:0]);
      end else if (shr[r][SHR_W-1]) begin
        clip[r] = COMP_MIN;
      end else begin
        clip[r] = COMP_MAX;
      end
    end
  end

  // stage 4: output register
  always_ff @(posedge clk) begin
    if (stg_ready[4]) begin
      for (int r = 0; r < 4; r++) begin
        s4_out[r] <= clip[r];
      end
      s4_sat <= |row_sat;
    end
  end

  assign result.valid     = stg_valid[NSTG-1];
  assign result.out_x     = s4_out[0];
  assign result.out_y     = s4_out[1];
  assign result.out_z     = s4_out[2];
  assign result.out_w     = s4_out[3];
  assign result.saturated = s4_sat;

  // flagged result has at least one clipped component
  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |->
      (result.out_x == COMP_MAX) || (result.out_x == COMP_MIN) ||
      (result.out_y == COMP_MAX) || (result.out_y == COMP_MIN) ||
      (result.out_z == COMP_MAX) || (result.out_z == COMP_MIN) ||
      (result.out_w == COMP_MAX) || (result.out_w == COMP_MIN))
    else $error("saturated flag without a clipped component");

  // a new result only comes from a full row-sum stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && stg_valid[4] && !$past(stg_valid[4]) |-> $past(stg_valid[3]))
    else $error("result appeared without a row sum behind it");

  // a held row sum is never dropped
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    stg_valid[3] && !stg_ready[3] |=> stg_valid[3])
    else $error("stalled row sum lost");

endmodule
